### src/lea_pkg.sv
// lea_pkg: shared types, constants and round functions for the lea block cipher
// no dependencies

package lea_pkg;

    localparam int MaxRounds = 32;
    localparam int RndW      = $clog2(MaxRounds);   // round index width
    localparam int QDepth    = 2;

    typedef enum logic [1:0] {
        KS_128 = 2'd0,
        KS_192 = 2'd1,
        KS_256 = 2'd2,
        KS_SAT = 2'd3
    } t_key_size;

    typedef enum logic [2:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_KSIZE = 3'd4
    } t_reg_idx;

    // one queued word between front and back
    typedef struct packed {
        logic        kind;
        logic        rekey;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_job;

    // six round keys of one round
    typedef logic [5:0][31:0] t_rk_set;

    function automatic logic [31:0] sched_const(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0: c = 32'hc3efe9db;
            3'd1: c = 32'h88c4d604;
            3'd2: c = 32'he789f229;
            3'd3: c = 32'hc6f98763;
            3'd4: c = 32'h15ea49e7;
            3'd5: c = 32'hf0bb4158;
            3'd6: c = 32'h13bc8ab8;
            default: c = 32'he204abf2;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

endpackage

### src/lea_front.sv
// lea_front: accepts input words, tracks a stale key schedule and queues jobs
// depends on lea_pkg

module lea_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic          i_kind,
    input  logic [63:0]   i_block_low,
    input  logic [63:0]   i_block_high,
    input  logic          i_cfg_we,
    output logic          o_q_valid,
    output lea_pkg::t_job o_q_job,
    input  logic          i_q_take
);
    import lea_pkg::*;

    logic   r_stale, n_stale;
    t_job   r_q [QDepth];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic   do_push;

    assign full      = (r_cnt == 2'(QDepth));
    assign do_push   = push && !full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_job   = r_q[r_rp];

    // schedule goes stale on any config write, cleared once a job carries rekey
    always_comb begin
        n_stale = r_stale;
        if (do_push) n_stale = 1'b0;
        if (i_cfg_we) n_stale = 1'b1;
    end

    // small job queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 1'b1;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_stale <= n_stale;
            if (do_push) r_wp <= ~r_wp;
            if (i_q_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(i_q_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= '{kind: i_kind, rekey: r_stale,
                                    block_low: i_block_low, block_high: i_block_high};
    end

endmodule

### src/lea_back.sv
// lea_back: key expansion into the round key memory and the round datapath
// depends on lea_pkg

module lea_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [255:0]  i_key,
    input  logic [1:0]    i_key_size,
    input  logic          i_q_valid,
    input  lea_pkg::t_job i_q_job,
    output logic          o_q_take,
    output logic          o_res_valid,
    output logic [127:0]  o_res,
    input  logic          i_res_take
);
    import lea_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_KEY  = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_LAST = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state      r_state;
    logic [RndW-1:0] r_rnd;       // current round index
    logic [RndW-1:0] r_last;      // rounds - 1
    logic [RndW-1:0] r_nrnd;      // rounds - 1 of the stored schedule
    logic [2:0]  r_mode;          // nk/2 - 2 ish: 0=128,1=192,2=256 one-hot-free
    logic [2:0]  r_ci;            // round index mod nk
    logic        r_dec;
    logic [3:0][31:0] r_x;
    logic [7:0][31:0] r_t;
    logic [7:0][31:0] r_c;
    t_rk_set     rk_mem [MaxRounds];
    t_rk_set     r_rk;
    logic [127:0] r_out;
    logic        r_out_v;

    logic [1:0]  mode;
    logic [3:0]  nk;
    logic [2:0]  ci;
    logic [31:0] c0;
    logic [7:0][31:0] t_nx;
    t_rk_set     rk_new;
    logic [3:0][31:0] x_nx;
    logic [RndW-1:0] rd_addr;
    logic [RndW-1:0] rounds_m1;

    assign mode = (i_key_size == KS_SAT) ? 2'(KS_256) : i_key_size;
    assign rounds_m1 = RndW'(23 + 4 * int'(mode));
    assign nk = (r_mode == 3'd0) ? 4'd4 : (r_mode == 3'd1) ? 4'd6 : 4'd8;

    // constant index runs as a wrapping counter
    assign ci = r_ci;
    assign c0 = r_c[ci];

    // one round of the key schedule
    always_comb begin
        logic [2:0] idx;
        idx = '0;
        t_nx = r_t;
        rk_new = '0;
        if (nk == 4'd4) begin
            t_nx[0] = rotl32(r_t[0] + c0, 5'd1);
            t_nx[1] = rotl32(r_t[1] + rotl32(c0, 5'd1), 5'd3);
            t_nx[2] = rotl32(r_t[2] + rotl32(c0, 5'd2), 5'd6);
            t_nx[3] = rotl32(r_t[3] + rotl32(c0, 5'd3), 5'd11);
            rk_new = {t_nx[1], t_nx[3], t_nx[1], t_nx[2], t_nx[1], t_nx[0]};
        end else begin
            for (int j = 0; j < 6; j++) begin
                if (nk == 4'd8) idx = 3'(6 * int'(r_rnd) + j);
                else            idx = 3'(j);
                case (j)
                    0: t_nx[idx] = rotl32(r_t[idx] + c0, 5'd1);
                    1: t_nx[idx] = rotl32(r_t[idx] + rotl32(c0, 5'd1), 5'd3);
                    2: t_nx[idx] = rotl32(r_t[idx] + rotl32(c0, 5'd2), 5'd6);
                    3: t_nx[idx] = rotl32(r_t[idx] + rotl32(c0, 5'd3), 5'd11);
                    4: t_nx[idx] = rotl32(r_t[idx] + rotl32(c0, 5'd4), 5'd13);
                    default: t_nx[idx] = rotl32(r_t[idx] + rotl32(c0, 5'd5), 5'd17);
                endcase
                rk_new[j] = t_nx[idx];
            end
        end
    end

    // one encryption or decryption round
    always_comb begin
        logic [31:0] p1, p2;
        p1 = '0;
        p2 = '0;
        if (!r_dec) begin
            x_nx[0] = rotl32((r_x[0] ^ r_rk[0]) + (r_x[1] ^ r_rk[1]), 5'd9);
            x_nx[1] = rotl32((r_x[1] ^ r_rk[2]) + (r_x[2] ^ r_rk[3]), 5'd27);
            x_nx[2] = rotl32((r_x[2] ^ r_rk[4]) + (r_x[3] ^ r_rk[5]), 5'd29);
            x_nx[3] = r_x[0];
        end else begin
            p1 = (rotl32(r_x[0], 5'd23) - (r_x[3] ^ r_rk[0])) ^ r_rk[1];
            p2 = (rotl32(r_x[1], 5'd5) - (p1 ^ r_rk[2])) ^ r_rk[3];
            x_nx[0] = r_x[3];
            x_nx[1] = p1;
            x_nx[2] = p2;
            x_nx[3] = (rotl32(r_x[2], 5'd3) - (p2 ^ r_rk[4])) ^ r_rk[5];
        end
    end

    // read address: the current round before the first round, then the one to run next
    always_comb begin
        if (r_state == ST_LAST)
            rd_addr = r_dec ? r_rnd - 1'b1 : r_rnd + 1'b1;
        else
            rd_addr = r_rnd;
    end

    assign o_q_take    = i_q_valid && (r_state == ST_IDLE);
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // round key memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_KEY) rk_mem[r_rnd] <= rk_new;
        r_rk <= rk_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_rnd   <= '0;
            r_nrnd  <= RndW'(23);
        end else begin
            // result register reloads in the cycle the old word leaves
            if (r_state == ST_DONE && (!r_out_v || i_res_take)) r_out_v <= 1'b1;
            else if (i_res_take) r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_dec <= i_q_job.kind;
                        r_x   <= {i_q_job.block_high, i_q_job.block_low};
                        if (i_q_job.rekey) begin
                            r_state <= ST_KEY;
                            r_rnd   <= '0;
                            r_ci    <= '0;
                            r_mode  <= {1'b0, mode};
                            r_last  <= rounds_m1;
                            r_t     <= i_key;
                            for (int k = 0; k < 8; k++) r_c[k] <= sched_const(3'(k));
                        end else begin
                            r_state <= ST_RUN;
                            r_rnd   <= i_q_job.kind ? r_nrnd : '0;
                        end
                    end
                end
                ST_KEY: begin
                    r_t <= t_nx;
                    r_c[ci] <= rotl32(c0, {1'b0, nk});
                    r_ci <= ({1'b0, r_ci} == nk - 4'd1) ? 3'd0 : r_ci + 3'd1;
                    if (r_rnd == r_last) begin
                        r_state <= ST_RUN;
                        r_nrnd  <= r_last;
                        r_rnd   <= r_dec ? r_last : '0;
                    end else begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                ST_RUN: begin
                    // this state waits on the memory read
                    r_state <= ST_LAST;
                end
                ST_LAST: begin
                    r_x <= x_nx;
                    r_rnd <= r_dec ? r_rnd - 1'b1 : r_rnd + 1'b1;
                    if ((r_dec && r_rnd == '0) || (!r_dec && r_rnd == r_nrnd))
                        r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_v || i_res_take) begin
                        r_out   <= {r_x[3], r_x[2], r_x[1], r_x[0]};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/lea_block_cipher.sv
// lea_block_cipher: top level of the lea block cipher
// depends on lea_pkg, lea_front, lea_back

// LEA on 128-bit blocks with 128, 192 or 256-bit keys. Write the key words and
// key size through the config port while idle; the first word pushed after any
// write first rebuilds the round key memory, one round per cycle (24, 28 or 32
// rounds). A block then runs one round per cycle from the round key memory,
// which gives one round key set per cycle, plus a read lead-in and result
// capture. One block is worked at a time; a two-entry queue at the input and
// the result register let both sides stall.

module lea_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_out_low,
    output logic [63:0] o_out_high,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import lea_pkg::*;

    logic [3:0][63:0] r_key;
    logic [1:0]       r_ksize;
    logic             q_valid, q_take, res_v;
    t_job             q_job;
    logic [127:0]     res;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_ksize <= 2'(KS_128);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0:  r_key[0] <= i_cfg_data;
                REG_KEY1:  r_key[1] <= i_cfg_data;
                REG_KEY2:  r_key[2] <= i_cfg_data;
                REG_KEY3:  r_key[3] <= i_cfg_data;
                REG_KSIZE: r_ksize  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    lea_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_kind, .i_block_low, .i_block_high,
        .i_cfg_we, .o_q_valid(q_valid), .o_q_job(q_job), .i_q_take(q_take)
    );

    lea_back u_back (
        .i_clk, .i_rst_n, .i_key(r_key), .i_key_size(r_ksize),
        .i_q_valid(q_valid), .i_q_job(q_job), .o_q_take(q_take),
        .o_res_valid(res_v), .o_res(res), .i_res_take(pop)
    );

    assign empty      = !res_v;
    assign o_out_low  = res[63:0];
    assign o_out_high = res[127:64];

endmodule

### test/lea_block_cipher_tb.sv
// lea_block_cipher_tb: self-checking testbench for the lea block cipher
// depends on lea_pkg and lea_block_cipher; checks every result word against
// an in-bench key schedule and round model

`timescale 1ns / 100ps

module lea_block_cipher_tb;
    import lea_pkg::*;

    localparam int          DrainCycles = 100;     // rekey plus one full block
    localparam logic [2:0]  RegUnused   = 3'd6;    // index outside the register map

    typedef struct {
        bit        kind;
        bit [63:0] lo;
        bit [63:0] hi;
    } t_stim;

    typedef struct {
        bit [63:0] lo;
        bit [63:0] hi;
    } t_block;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_kind;
    logic [63:0] i_block_low;
    logic [63:0] i_block_high;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_out_low;
    logic [63:0] o_out_high;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    lea_block_cipher uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .empty        (empty),
        .pop          (pop),
        .o_out_low    (o_out_low),
        .o_out_high   (o_out_high),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // model state: key registers and expanded schedule
    bit [63:0] key_reg [4];
    bit [1:0]  ksize_reg;
    bit        sched_stale;
    bit [31:0] round_keys [6*MaxRounds];
    int        num_rounds;

    t_block    pending_blocks [$];
    int        mismatches;
    int        items_sent;
    int        blocks_checked;
    int        burst_left;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [31:0] rol(bit [31:0] v, int n);
        n = n & 31;
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic bit [31:0] ror(bit [31:0] v, int n);
        return rol(v, (32 - (n & 31)) & 31);
    endfunction

    // key schedule into round_keys
    function automatic void expand_schedule();
        int        trot [6] = '{1, 3, 6, 11, 13, 17};
        bit [31:0] t [8];
        bit [31:0] c [8];
        bit [31:0] c0;
        int        mode, nk, ci, idx;
        mode = (ksize_reg >= KS_256) ? 2 : int'(ksize_reg);
        nk = 4 + 2 * mode;
        num_rounds = 24 + 4 * mode;
        for (int i = 0; i < 4; i++) begin
            t[2*i]   = key_reg[i][31:0];
            t[2*i+1] = key_reg[i][63:32];
        end
        for (int i = 0; i < 8; i++) c[i] = sched_const(3'(i));
        for (int i = 0; i < num_rounds; i++) begin
            ci = i % nk;
            c0 = c[ci];
            c[ci] = rol(c0, nk);
            if (nk == 4) begin
                for (int j = 0; j < 4; j++) t[j] = rol(t[j] + rol(c0, j), trot[j]);
                round_keys[6*i]   = t[0];
                round_keys[6*i+1] = t[1];
                round_keys[6*i+2] = t[2];
                round_keys[6*i+3] = t[1];
                round_keys[6*i+4] = t[3];
                round_keys[6*i+5] = t[1];
            end else begin
                for (int j = 0; j < 6; j++) begin
                    idx = (nk == 8) ? ((6 * i + j) & 7) : j;
                    t[idx] = rol(t[idx] + rol(c0, j), trot[j]);
                    round_keys[6*i+j] = t[idx];
                end
            end
        end
        sched_stale = 1'b0;
    endfunction

    // encrypt or decrypt one block with the current schedule
    function automatic t_block cipher_block(t_stim s);
        bit [31:0] x0, x1, x2, x3, n0, n1, n2, p1, p2, p3;
        int        b;
        t_block    r;
        if (sched_stale) expand_schedule();
        x0 = s.lo[31:0]; x1 = s.lo[63:32]; x2 = s.hi[31:0]; x3 = s.hi[63:32];
        if (!s.kind) begin
            for (int rd = 0; rd < num_rounds; rd++) begin
                b = 6 * rd;
                n0 = rol((x0 ^ round_keys[b])   + (x1 ^ round_keys[b+1]), 9);
                n1 = ror((x1 ^ round_keys[b+2]) + (x2 ^ round_keys[b+3]), 5);
                n2 = ror((x2 ^ round_keys[b+4]) + (x3 ^ round_keys[b+5]), 3);
                x3 = x0; x0 = n0; x1 = n1; x2 = n2;
            end
        end else begin
            for (int rd = num_rounds - 1; rd >= 0; rd--) begin
                b = 6 * rd;
                p1 = (ror(x0, 9) - (x3 ^ round_keys[b]))   ^ round_keys[b+1];
                p2 = (rol(x1, 5) - (p1 ^ round_keys[b+2])) ^ round_keys[b+3];
                p3 = (rol(x2, 3) - (p2 ^ round_keys[b+4])) ^ round_keys[b+5];
                x0 = x3; x1 = p1; x2 = p2; x3 = p3;
            end
        end
        r.lo = {x1, x0};
        r.hi = {x3, x2};
        return r;
    endfunction

    // register write; enable stays high for back-to-back writes
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < REG_KSIZE) begin
            key_reg[idx] = data;
            sched_stale = 1'b1;
        end else if (idx == REG_KSIZE) begin
            ksize_reg = data[1:0];
            sched_stale = 1'b1;
        end
    endtask

    task automatic load_key(bit [63:0] k0, bit [63:0] k1, bit [63:0] k2, bit [63:0] k3,
                            bit [1:0] ks);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        // upper bits of the size word are don't-care
        write_reg(REG_KSIZE, {$urandom, $urandom} & ~64'd3 | 64'(ks));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // send one word, with burst gaps in front of it
    task automatic send_word(t_stim s);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
        burst_left--;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_kind       <= s.kind;
        i_block_low  <= s.lo;
        i_block_high <= s.hi;
        forever begin
            @(negedge i_clk);
            if (!full) break;
        end
        @(posedge i_clk);
        pending_blocks.push_back(cipher_block(s));
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic bit [63:0] rand_half();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: stall style is redrawn at random at regular intervals
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= $urandom_range(0, 1);
            2: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= ((stall_cnt / 40) % 2 == 0);
        endcase
    end

    // result check, sampled away from the clock edge
    always @(negedge i_clk) begin
        t_block want;
        if (i_rst_n && !empty && pop) begin
            if (pending_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: low=%h high=%h", o_out_low, o_out_high);
            end else begin
                want = pending_blocks.pop_front();
                blocks_checked++;
                if (o_out_low !== want.lo) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("out_low: expected %h got %h", want.lo, o_out_low);
                end
                if (o_out_high !== want.hi) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("out_high: expected %h got %h", want.hi, o_out_high);
                end
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    t_stim directed [] = '{
        '{1'b0, 64'd0, 64'd0},
        '{1'b1, 64'd0, 64'd0},
        '{1'b0, '1, '1},
        '{1'b1, '1, '1},
        '{1'b0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
        '{1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555},
        '{1'b0, 64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000},
        '{1'b1, 64'h0000_0001_0000_0000, 64'h8000_0000_0000_0000},
        '{1'b0, 64'h1032_5476_98ba_dcfe, 64'h0123_4567_89ab_cdef},
        '{1'b1, 64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff}
    };

    // main sequence
    initial begin
        t_stim s;
        int    phase_items;
        push = 1'b0; i_kind = 1'b0; i_block_low = '0; i_block_high = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        mismatches = 0; items_sent = 0; blocks_checked = 0; burst_left = 0;
        key_reg = '{default: '0}; ksize_reg = KS_128; sched_stale = 1'b1;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset key
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // writes to an unmapped index must leave the key alone
        write_reg(RegUnused, '1);
        write_reg(3'(REG_KSIZE) + 3'd1, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        foreach (directed[i]) if (i < 4) send_word(directed[i]);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_key('1, '1, '1, '1, KS_128);
                1: load_key({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, '1, KS_192);
                2: load_key({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom}, KS_256);
                3: load_key({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom}, KS_SAT);
                4: load_key('0, '0, '0, '0, KS_256);
                5: load_key('1, '1, '1, '1, KS_192);
                6: load_key({$urandom, $urandom}, {$urandom, $urandom},
                            '1, '1, KS_128);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  2'($urandom_range(0, 3)));
            endcase
            // a key change also hits the first word of each phase
            foreach (directed[i]) if (i < 2) send_word(directed[i]);
            phase_items = 190;
            for (int n = 0; n < phase_items; n++) begin
                s.kind = $urandom_range(0, 1);
                s.lo   = rand_half();
                s.hi   = rand_half();
                send_word(s);
                // hold off the sender until the block runs dry
                if (n == 95) begin
                    push <= 1'b0;
                    while (pending_blocks.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
            drain();
        end

        $display("sent %0d words over 9 key settings, all key sizes incl. saturated size",
                 items_sent);
        $display("checked %0d result words, encrypt and decrypt under random stalls",
                 blocks_checked);
        if (mismatches == 0 && pending_blocks.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
